@@ src/rsvm_pkg.sv @@
// Shared constants, opcodes, types and the size-adjust function of the VM execute block.
package rsvm_pkg;

  localparam int NUM_REGS    = 16;
  localparam int REG_IW      = $clog2(NUM_REGS);
  localparam int STACK_DEPTH = 256;
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int SSW         = SAW + 1;
  localparam int DATA_DEPTH  = 256;
  localparam int DAW         = $clog2(DATA_DEPTH);
  localparam int DSW         = DAW + 1;
  localparam int FRAME_DEPTH = 16;
  localparam int FAW         = $clog2(FRAME_DEPTH);
  localparam int FCW         = FAW + 1;
  localparam logic [REG_IW-1:0] FP_INDEX   = REG_IW'(14);
  localparam logic [REG_IW-1:0] FLAG_INDEX = REG_IW'(15);

  localparam logic [63:0] ALL_ONES = '1;

  localparam logic [4:0] OP_INVALID  = 5'd0;
  localparam logic [4:0] OP_MOV      = 5'd1;
  localparam logic [4:0] OP_IADD_C   = 5'd2;
  localparam logic [4:0] OP_IADD_R   = 5'd3;
  localparam logic [4:0] OP_ISUB_C   = 5'd4;
  localparam logic [4:0] OP_ISUB_R   = 5'd5;
  localparam logic [4:0] OP_POP_R    = 5'd6;
  localparam logic [4:0] OP_PUSH_C   = 5'd7;
  localparam logic [4:0] OP_PUSH_R   = 5'd8;
  localparam logic [4:0] OP_STORE_L  = 5'd9;
  localparam logic [4:0] OP_LOAD_L   = 5'd10;
  localparam logic [4:0] OP_STORE_G  = 5'd11;
  localparam logic [4:0] OP_LOAD_G   = 5'd12;
  localparam logic [4:0] OP_DATA_ADD = 5'd13;
  localparam logic [4:0] OP_IPRINT   = 5'd14;
  localparam logic [4:0] OP_CALL     = 5'd15;
  localparam logic [4:0] OP_CALL_R   = 5'd16;
  localparam logic [4:0] OP_RET      = 5'd17;
  localparam logic [4:0] OP_RET_NM   = 5'd18;
  localparam logic [4:0] OP_RET_NP   = 5'd19;
  localparam logic [4:0] OP_BEQ      = 5'd20;
  localparam logic [4:0] OP_BGT      = 5'd21;
  localparam logic [4:0] OP_BLT      = 5'd22;
  localparam logic [4:0] OP_BLE      = 5'd23;
  localparam logic [4:0] OP_BGE      = 5'd24;
  localparam logic [4:0] OP_CMPI     = 5'd25;
  localparam logic [4:0] OP_SRESIZE  = 5'd26;
  localparam logic [4:0] OP_DRESIZE  = 5'd27;
  localparam logic [4:0] OP_DSIZE    = 5'd28;
  localparam logic [4:0] OP_SET_D_AV = 5'd29;
  localparam logic [4:0] OP_EXIT     = 5'd30;
  localparam logic [4:0] OP_NOOP     = 5'd31;

  localparam logic [3:0] SC_OK        = 4'd0;
  localparam logic [3:0] SC_BAD_OP    = 4'd1;
  localparam logic [3:0] SC_STK_ADDR  = 4'd2;
  localparam logic [3:0] SC_DAT_EMPTY = 4'd3;
  localparam logic [3:0] SC_DAT_ADDR  = 4'd4;
  localparam logic [3:0] SC_POP_EMPTY = 4'd5;
  localparam logic [3:0] SC_CAPACITY  = 4'd6;
  localparam logic [3:0] SC_NO_FRAME  = 4'd7;
  localparam logic [3:0] SC_FRAME_OVF = 4'd8;

  // flag bits: Z, C (greater), N (less)
  localparam logic [2:0] FLAG_Z = 3'b001;
  localparam logic [2:0] FLAG_C = 3'b010;
  localparam logic [2:0] FLAG_N = 3'b100;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] op_c;
    logic [31:0] pc_now;
    logic        is_branch;
    logic [2:0]  br_mask;
  } entry_t;

  // base + signed delta within [0, depth]; {ok, result}
  function automatic logic [64:0] adjust(logic [63:0] base, logic [63:0] delta,
                                         logic [63:0] depth);
    logic [63:0] neg;
    logic [64:0] r;
    neg = 64'd0 - delta;
    if (delta[63]) begin
      r = (neg > base) ? 65'd0 : {1'b1, base - neg};
    end else begin
      r = (base > depth || delta > depth - base) ? 65'd0 : {1'b1, base + delta};
    end
    return r;
  endfunction

endpackage

@@ src/register_stack_vm_execute.sv @@
// Top level of the register/stack VM execute block.
// One instruction per input beat; each passes through the execute unit's EXEC state (read
// the register file and issue the stack or data memory read) and then its WB state (write
// back and load the result register), which waits while the result beat is not yet taken.
// The unit takes no new instruction until it is back in EXEC. A resize or return that grows
// the stack or data segment by n entries (at most 256) then holds the execute unit while
// the uncovered entries are marked empty one per cycle; its result beat is already out by
// then. A two-entry queue in front keeps input accepted while the result waits to be taken.
// exit_pc is written on the cfg channel, which is always ready.
module register_stack_vm_execute (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [223:0]   in_tdata,   // operand_a, operand_b, operand_c, pc_now
  input  logic [4:0]     in_tuser,   // cmd
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [103:0]   out_tdata,  // pc_value, print_value, status, zero pad
  output logic [1:0]     out_tuser,  // pc_write, print_valid
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import rsvm_pkg::*;

  logic        q_valid, q_ready;
  entry_t      q_entry;
  logic [31:0] exit_pc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_pc_r <= 32'd0;
    end else if (cfg_valid) begin
      exit_pc_r <= cfg_data;
    end
  end

  rsvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry)
  );

  rsvm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .exit_pc    (exit_pc_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ src/rsvm_front.sv @@
// Input queue: takes instruction beats, decodes branch conditions, holds two entries.
module rsvm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [223:0]    in_tdata,
  input  logic [4:0]      in_tuser,
  output logic            q_valid,
  input  logic            q_ready,
  output rsvm_pkg::entry_t q_entry
);
  import rsvm_pkg::*;

  entry_t     slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  entry_t     dec;

  always_comb begin
    dec.cmd       = in_tuser;
    dec.op_a      = in_tdata[63:0];
    dec.op_b      = in_tdata[127:64];
    dec.op_c      = in_tdata[191:128];
    dec.pc_now    = in_tdata[223:192];
    dec.is_branch = 1'b1;
    case (in_tuser)
      OP_BEQ:  dec.br_mask = FLAG_Z;
      OP_BGT:  dec.br_mask = FLAG_C;
      OP_BLT:  dec.br_mask = FLAG_N;
      OP_BLE:  dec.br_mask = FLAG_N | FLAG_Z;
      OP_BGE:  dec.br_mask = FLAG_C | FLAG_Z;
      default: begin
        dec.br_mask   = 3'b000;
        dec.is_branch = 1'b0;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_entry   = slot_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;
  assign wp_nxt    = push ? ~wp_r : wp_r;
  assign rp_nxt    = pop ? ~rp_r : rp_r;
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= dec;
    end
  end

endmodule

@@ src/rsvm_back.sv @@
// Execute unit: register file, operand stack, data segment, frames, result register.
module rsvm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      exit_pc,
  input  logic             q_valid,
  output logic             q_ready,
  input  rsvm_pkg::entry_t q_entry,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [103:0]     out_tdata,
  output logic [1:0]       out_tuser
);
  import rsvm_pkg::*;

  localparam logic [1:0] ST_EXEC = 2'd0;
  localparam logic [1:0] ST_WB   = 2'd1;
  localparam logic [1:0] ST_CLR  = 2'd2;

  localparam int CLW = (SSW > DSW) ? SSW : DSW;

  localparam logic [1:0] SRC_VAL = 2'd0;
  localparam logic [1:0] SRC_STK = 2'd1;
  localparam logic [1:0] SRC_DAT = 2'd2;

  typedef struct packed {
    logic              rf_we;
    logic [REG_IW-1:0] rf_idx;
    logic [63:0]       rf_val;
    logic [1:0]        rf_src;
    logic              stk_we;
    logic [SAW-1:0]    stk_addr;
    logic [63:0]       stk_wdata;
    logic              dat_we;
    logic [DAW-1:0]    dat_addr;
    logic [63:0]       dat_wdata;
    logic              ssz_we;
    logic              ssz_clr;
    logic [SSW-1:0]    ssz_new;
    logic              dsz_we;
    logic              dsz_clr;
    logic [DSW-1:0]    dsz_new;
    logic              fr_push;
    logic              fr_pop;
    logic              pcw;
    logic [31:0]       pcv;
    logic              pv;
    logic [63:0]       prv;
    logic [3:0]        status;
  } pend_t;

  logic [1:0]     state_r, state_nxt;
  pend_t          pend_r, pend;
  logic [63:0]    rf_r [NUM_REGS];
  logic [63:0]    stk_mem [STACK_DEPTH];
  logic [63:0]    dat_mem [DATA_DEPTH];
  logic           stk_vld_r [STACK_DEPTH];
  logic           dat_vld_r [DATA_DEPTH];
  logic [SSW-1:0] ssz_r;
  logic [DSW-1:0] dsz_r;
  logic [31:0]    fr_pc_r   [FRAME_DEPTH];
  logic [63:0]    fr_fp_r   [FRAME_DEPTH];
  logic [SSW-1:0] fr_size_r [FRAME_DEPTH];
  logic [FCW-1:0] fcnt_r;
  logic [63:0]    stk_q_r, dat_q_r;
  logic           stk_qv_r, dat_qv_r;
  logic [SAW-1:0] stk_raddr;
  logic [DAW-1:0] dat_raddr;
  logic           out_valid_r;
  logic [103:0]   out_data_r;
  logic [1:0]     out_user_r;
  logic           exec_fire, wb_fire;
  logic           stk_grow, dat_grow, clr_start, clr_last;
  logic [CLW-1:0] clr_ptr_r, clr_end_r;
  logic           clr_dat_r;

  logic [63:0]    a, b, c, p2_idx, rd_a, rd_p2, fp, fl, loc, diff, rdelta, wb_val;
  logic [FAW-1:0] top;
  logic [64:0]    adj;

  function automatic logic idx_ok(logic [63:0] x);
    return x[63:REG_IW] == '0;
  endfunction

  assign q_ready   = (state_r == ST_EXEC);
  assign exec_fire = q_valid && q_ready;
  assign wb_fire   = (state_r == ST_WB) && (!out_valid_r || out_tready);

  // growth uncovers entries that must read zero: cleared one per cycle after write-back
  assign stk_grow  = pend_r.ssz_clr && (pend_r.ssz_new > ssz_r);
  assign dat_grow  = pend_r.dsz_clr && (pend_r.dsz_new > dsz_r);
  assign clr_start = stk_grow || dat_grow;
  assign clr_last  = ((clr_ptr_r + CLW'(1)) == clr_end_r);

  always_comb begin
    case (state_r)
      ST_EXEC: state_nxt = exec_fire ? ST_WB : ST_EXEC;
      ST_WB:   state_nxt = wb_fire ? (clr_start ? ST_CLR : ST_EXEC) : ST_WB;
      ST_CLR:  state_nxt = clr_last ? ST_EXEC : ST_CLR;
      default: state_nxt = ST_EXEC;
    endcase
  end

  always_comb begin
    a      = q_entry.op_a;
    b      = q_entry.op_b;
    c      = q_entry.op_c;
    p2_idx = (q_entry.cmd == OP_IADD_R || q_entry.cmd == OP_ISUB_R) ? c : b;
    rd_a   = idx_ok(a) ? rf_r[a[REG_IW-1:0]] : 64'd0;
    rd_p2  = idx_ok(p2_idx) ? rf_r[p2_idx[REG_IW-1:0]] : 64'd0;
    fp     = rf_r[FP_INDEX];
    fl     = rf_r[FLAG_INDEX];
    top    = FAW'(fcnt_r - FCW'(1));
    diff   = rd_a - rd_p2;
    loc    = (q_entry.cmd == OP_STORE_G || q_entry.cmd == OP_LOAD_G) && b == ALL_ONES
             ? c : rd_p2 + c;
    rdelta = (q_entry.cmd == OP_RET_NM) ? 64'd0 - a :
             (q_entry.cmd == OP_RET_NP) ? a : 64'd0;
    case (q_entry.cmd)
      OP_SRESIZE: adj = adjust(64'(ssz_r), a, 64'(STACK_DEPTH));
      OP_DRESIZE: adj = adjust(64'(dsz_r), a, 64'(DATA_DEPTH));
      default:    adj = adjust(64'(fr_size_r[top]), rdelta, 64'(STACK_DEPTH));
    endcase
    stk_raddr = (q_entry.cmd == OP_POP_R) ? SAW'(ssz_r - SSW'(1)) : loc[SAW-1:0];
    dat_raddr = loc[DAW-1:0];

    pend           = '0;
    pend.rf_idx    = a[REG_IW-1:0];
    pend.rf_src    = SRC_VAL;
    pend.stk_addr  = ssz_r[SAW-1:0];
    pend.dat_addr  = dsz_r[DAW-1:0];
    pend.ssz_new   = ssz_r;
    pend.dsz_new   = dsz_r;
    pend.status    = SC_OK;
    case (q_entry.cmd)
      OP_INVALID: pend.status = SC_BAD_OP;
      OP_MOV: begin
        pend.rf_we  = idx_ok(a);
        pend.rf_val = b;
      end
      OP_IADD_C, OP_ISUB_C: begin
        pend.rf_we  = idx_ok(a);
        pend.rf_val = (q_entry.cmd == OP_IADD_C) ? rd_p2 + c : rd_p2 - c;
      end
      OP_IADD_R, OP_ISUB_R: begin
        pend.rf_we  = idx_ok(a);
        pend.rf_val = (q_entry.cmd == OP_IADD_R) ? (idx_ok(b) ? rf_r[b[REG_IW-1:0]] : 64'd0)
                      + rd_p2 : (idx_ok(b) ? rf_r[b[REG_IW-1:0]] : 64'd0) - rd_p2;
      end
      OP_POP_R: begin
        if (ssz_r == '0) begin
          pend.status = SC_POP_EMPTY;
        end else begin
          pend.ssz_we  = 1'b1;
          pend.ssz_new = ssz_r - SSW'(1);
          pend.rf_we   = idx_ok(a);
          pend.rf_src  = SRC_STK;
        end
      end
      OP_PUSH_C, OP_PUSH_R: begin
        if (ssz_r >= SSW'(STACK_DEPTH)) begin
          pend.status = SC_CAPACITY;
        end else begin
          pend.stk_we    = 1'b1;
          pend.stk_wdata = (q_entry.cmd == OP_PUSH_C) ? a : rd_a;
          pend.ssz_we    = 1'b1;
          pend.ssz_new   = ssz_r + SSW'(1);
        end
      end
      OP_STORE_L, OP_LOAD_L: begin
        if (loc >= 64'(ssz_r)) begin
          pend.status = SC_STK_ADDR;
        end else if (q_entry.cmd == OP_STORE_L) begin
          pend.stk_we    = 1'b1;
          pend.stk_addr  = loc[SAW-1:0];
          pend.stk_wdata = rd_a;
        end else begin
          pend.rf_we  = idx_ok(a);
          pend.rf_src = SRC_STK;
        end
      end
      OP_STORE_G, OP_LOAD_G: begin
        if (dsz_r == '0) begin
          pend.status = SC_DAT_EMPTY;
        end else if (loc >= 64'(dsz_r)) begin
          pend.status = SC_DAT_ADDR;
        end else if (q_entry.cmd == OP_STORE_G) begin
          pend.dat_we    = 1'b1;
          pend.dat_addr  = loc[DAW-1:0];
          pend.dat_wdata = rd_a;
        end else begin
          pend.rf_we  = idx_ok(a);
          pend.rf_src = SRC_DAT;
        end
      end
      OP_DATA_ADD: begin
        if (dsz_r >= DSW'(DATA_DEPTH)) begin
          pend.status = SC_CAPACITY;
        end else begin
          pend.dat_we    = 1'b1;
          pend.dat_wdata = (a == ALL_ONES) ? b : rd_a;
          pend.dsz_we    = 1'b1;
          pend.dsz_new   = dsz_r + DSW'(1);
        end
      end
      OP_IPRINT: begin
        pend.pv  = 1'b1;
        pend.prv = rd_a;
      end
      OP_CALL, OP_CALL_R: begin
        if (fcnt_r >= FCW'(FRAME_DEPTH)) begin
          pend.status = SC_FRAME_OVF;
        end else begin
          pend.fr_push = 1'b1;
          pend.rf_we   = 1'b1;
          pend.rf_idx  = FP_INDEX;
          pend.rf_val  = 64'(ssz_r);
          pend.pcw     = 1'b1;
          pend.pcv     = (q_entry.cmd == OP_CALL) ? a[31:0] : rd_a[31:0];
        end
      end
      OP_RET, OP_RET_NM, OP_RET_NP: begin
        if (fcnt_r == '0) begin
          pend.status = SC_NO_FRAME;
        end else if (!adj[64]) begin
          pend.status = SC_CAPACITY;
        end else begin
          pend.fr_pop  = 1'b1;
          pend.rf_we   = 1'b1;
          pend.rf_idx  = FP_INDEX;
          pend.rf_val  = fr_fp_r[top];
          pend.pcw     = 1'b1;
          pend.pcv     = fr_pc_r[top];
          pend.ssz_we  = 1'b1;
          pend.ssz_clr = 1'b1;
          pend.ssz_new = SSW'(adj[63:0]);
        end
      end
      OP_BEQ, OP_BGT, OP_BLT, OP_BLE, OP_BGE: begin
        pend.pcw = q_entry.is_branch && ((fl[2:0] & q_entry.br_mask) != 3'b000);
        pend.pcv = pend.pcw ? a[31:0] : 32'd0;
      end
      OP_CMPI: begin
        pend.rf_we  = 1'b1;
        pend.rf_idx = FLAG_INDEX;
        pend.rf_val = {fl[63:3], (diff == 64'd0) ? FLAG_Z : (diff[63] ? FLAG_N : FLAG_C)};
      end
      OP_SRESIZE: begin
        if (!adj[64]) begin
          pend.status = SC_CAPACITY;
        end else begin
          pend.ssz_we  = 1'b1;
          pend.ssz_clr = 1'b1;
          pend.ssz_new = SSW'(adj[63:0]);
        end
      end
      OP_DRESIZE: begin
        if (!adj[64]) begin
          pend.status = SC_CAPACITY;
        end else begin
          pend.dsz_we  = 1'b1;
          pend.dsz_clr = 1'b1;
          pend.dsz_new = DSW'(adj[63:0]);
        end
      end
      OP_DSIZE: begin
        pend.rf_we  = idx_ok(a);
        pend.rf_val = 64'(dsz_r);
      end
      OP_SET_D_AV: begin
        if (dsz_r == '0) begin
          pend.status = SC_DAT_EMPTY;
        end else if (a >= 64'(dsz_r)) begin
          pend.status = SC_DAT_ADDR;
        end else begin
          pend.dat_we    = 1'b1;
          pend.dat_addr  = a[DAW-1:0];
          pend.dat_wdata = b;
        end
      end
      OP_EXIT: begin
        pend.pcw = 1'b1;
        pend.pcv = exit_pc;
      end
      default: pend.status = SC_OK;
    endcase
  end

  always_comb begin
    case (pend_r.rf_src)
      SRC_STK: wb_val = stk_qv_r ? stk_q_r : 64'd0;
      SRC_DAT: wb_val = dat_qv_r ? dat_q_r : 64'd0;
      default: wb_val = pend_r.rf_val;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      out_valid_r <= 1'b0;
      ssz_r       <= '0;
      dsz_r       <= '0;
      fcnt_r      <= '0;
      clr_ptr_r   <= '0;
      clr_end_r   <= '0;
      clr_dat_r   <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= 64'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_vld_r[i] <= 1'b0;
      for (int i = 0; i < DATA_DEPTH; i++) dat_vld_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wb_fire) begin
        if (pend_r.rf_we) rf_r[pend_r.rf_idx] <= wb_val;
        if (pend_r.ssz_we) ssz_r <= pend_r.ssz_new;
        if (pend_r.dsz_we) dsz_r <= pend_r.dsz_new;
        if (stk_grow) begin
          clr_dat_r <= 1'b0;
          clr_ptr_r <= CLW'(ssz_r);
          clr_end_r <= CLW'(pend_r.ssz_new);
        end
        if (dat_grow) begin
          clr_dat_r <= 1'b1;
          clr_ptr_r <= CLW'(dsz_r);
          clr_end_r <= CLW'(pend_r.dsz_new);
        end
        if (pend_r.stk_we) stk_vld_r[pend_r.stk_addr] <= 1'b1;
        if (pend_r.dat_we) dat_vld_r[pend_r.dat_addr] <= 1'b1;
        if (pend_r.fr_push) fcnt_r <= fcnt_r + FCW'(1);
        if (pend_r.fr_pop) fcnt_r <= fcnt_r - FCW'(1);
      end
      if (state_r == ST_CLR) begin
        if (clr_dat_r) begin
          dat_vld_r[clr_ptr_r[DAW-1:0]] <= 1'b0;
        end else begin
          stk_vld_r[clr_ptr_r[SAW-1:0]] <= 1'b0;
        end
        clr_ptr_r <= clr_ptr_r + CLW'(1);
      end
    end
  end

  // payload and memories
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      pend_r   <= pend;
      stk_q_r  <= stk_mem[stk_raddr];
      stk_qv_r <= stk_vld_r[stk_raddr];
      dat_q_r  <= dat_mem[dat_raddr];
      dat_qv_r <= dat_vld_r[dat_raddr];
      if (pend.fr_push) begin
        fr_pc_r[fcnt_r[FAW-1:0]]   <= q_entry.pc_now;
        fr_fp_r[fcnt_r[FAW-1:0]]   <= fp;
        fr_size_r[fcnt_r[FAW-1:0]] <= ssz_r;
      end
    end
    if (wb_fire) begin
      if (pend_r.stk_we) stk_mem[pend_r.stk_addr] <= pend_r.stk_wdata;
      if (pend_r.dat_we) dat_mem[pend_r.dat_addr] <= pend_r.dat_wdata;
      out_data_r <= {4'd0, pend_r.status, pend_r.prv, pend_r.pcv};
      out_user_r <= {pend_r.pv, pend_r.pcw};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ dv/tb_register_stack_vm_execute.sv @@
// Self-checking testbench for the VM execute block: directed and random instruction streams.
module tb_register_stack_vm_execute;
  timeunit 1ns;
  timeprecision 1ps;
  import rsvm_pkg::*;

  typedef struct {
    logic [4:0]  cmd;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [31:0] pc;
  } instr_t;

  typedef struct {
    logic        pc_write;
    logic [31:0] pc_value;
    logic        print_valid;
    logic [63:0] print_value;
    logic [3:0]  status;
  } outcome_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [223:0] in_tdata;
  logic [4:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;

  register_stack_vm_execute u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // shadow machine state
  logic [63:0] vm_regs [NUM_REGS];
  logic [63:0] vm_stack [STACK_DEPTH];
  bit          vm_stack_ok [STACK_DEPTH];
  int          vm_stack_sz;
  logic [63:0] vm_data [DATA_DEPTH];
  bit          vm_data_ok [DATA_DEPTH];
  int          vm_data_sz;
  logic [31:0] vm_frm_pc [FRAME_DEPTH];
  logic [63:0] vm_frm_fp [FRAME_DEPTH];
  int          vm_frm_sz [FRAME_DEPTH];
  int          vm_frm_cnt;
  logic [31:0] vm_exit_pc;

  instr_t   instr_q [$];
  outcome_t outcome_q [$];
  instr_t   cur_instr;
  int       acc_seen;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_cycles;
  int       err_cnt;
  int       n_exec;
  int       n_redirect;
  int       n_print;
  int       n_fault;

  function automatic logic [63:0] rd_reg(logic [63:0] idx);
    return (idx < NUM_REGS) ? vm_regs[idx] : 64'd0;
  endfunction

  function automatic void wr_reg(logic [63:0] idx, logic [63:0] v);
    if (idx < NUM_REGS) vm_regs[idx] = v;
  endfunction

  // new size = base + signed delta, kept within 0..depth
  function automatic bit size_after(logic [63:0] base, logic [63:0] delta, int depth,
                                    output int nsz);
    logic [63:0] mag;
    nsz = 0;
    if (delta[63]) begin
      mag = -delta;
      if (mag > base) return 0;
      nsz = int'(base - mag);
    end else begin
      if (base > depth || delta > depth - base) return 0;
      nsz = int'(base + delta);
    end
    return 1;
  endfunction

  function automatic logic [3:0] unwind_frame(logic [63:0] delta, output logic [31:0] pcv);
    int top;
    int nsz;
    pcv = '0;
    if (vm_frm_cnt == 0) return SC_NO_FRAME;
    top = vm_frm_cnt - 1;
    if (!size_after(64'(vm_frm_sz[top]), delta, STACK_DEPTH, nsz)) return SC_CAPACITY;
    wr_reg(64'(FP_INDEX), vm_frm_fp[top]);
    pcv = vm_frm_pc[top];
    for (int i = vm_stack_sz; i < nsz; i++) vm_stack_ok[i] = 0;
    vm_stack_sz = nsz;
    vm_frm_cnt = top;
    return SC_OK;
  endfunction

  function automatic logic [3:0] enter_frame(logic [31:0] target, logic [31:0] pc_now,
                                             output logic [31:0] pcv);
    pcv = '0;
    if (vm_frm_cnt >= FRAME_DEPTH) return SC_FRAME_OVF;
    vm_frm_pc[vm_frm_cnt] = pc_now;
    vm_frm_fp[vm_frm_cnt] = rd_reg(64'(FP_INDEX));
    vm_frm_sz[vm_frm_cnt] = vm_stack_sz;
    vm_frm_cnt++;
    wr_reg(64'(FP_INDEX), 64'(vm_stack_sz));
    pcv = target;
    return SC_OK;
  endfunction

  function automatic outcome_t execute_instr(instr_t t);
    outcome_t    r;
    logic [63:0] fl;
    logic [63:0] loc;
    logic [63:0] d;
    bit          take;
    int          nsz;
    r = '{default: '0};
    take = 0;
    fl = rd_reg(64'(FLAG_INDEX));
    case (t.cmd)
      OP_INVALID:  r.status = SC_BAD_OP;
      OP_MOV:      wr_reg(t.a, t.b);
      OP_IADD_C:   wr_reg(t.a, rd_reg(t.b) + t.c);
      OP_IADD_R:   wr_reg(t.a, rd_reg(t.b) + rd_reg(t.c));
      OP_ISUB_C:   wr_reg(t.a, rd_reg(t.b) - t.c);
      OP_ISUB_R:   wr_reg(t.a, rd_reg(t.b) - rd_reg(t.c));
      OP_POP_R: begin
        if (vm_stack_sz == 0) r.status = SC_POP_EMPTY;
        else begin
          vm_stack_sz--;
          wr_reg(t.a, vm_stack_ok[vm_stack_sz] ? vm_stack[vm_stack_sz] : 64'd0);
        end
      end
      OP_PUSH_C, OP_PUSH_R: begin
        if (vm_stack_sz >= STACK_DEPTH) r.status = SC_CAPACITY;
        else begin
          vm_stack[vm_stack_sz] = (t.cmd == OP_PUSH_C) ? t.a : rd_reg(t.a);
          vm_stack_ok[vm_stack_sz] = 1;
          vm_stack_sz++;
        end
      end
      OP_STORE_L, OP_LOAD_L: begin
        loc = rd_reg(t.b) + t.c;
        if (loc >= vm_stack_sz) r.status = SC_STK_ADDR;
        else if (t.cmd == OP_STORE_L) begin
          vm_stack[loc] = rd_reg(t.a);
          vm_stack_ok[loc] = 1;
        end else wr_reg(t.a, vm_stack_ok[loc] ? vm_stack[loc] : 64'd0);
      end
      OP_STORE_G, OP_LOAD_G: begin
        loc = (t.b == ALL_ONES) ? t.c : rd_reg(t.b) + t.c;
        if (vm_data_sz == 0) r.status = SC_DAT_EMPTY;
        else if (loc >= vm_data_sz) r.status = SC_DAT_ADDR;
        else if (t.cmd == OP_STORE_G) begin
          vm_data[loc] = rd_reg(t.a);
          vm_data_ok[loc] = 1;
        end else wr_reg(t.a, vm_data_ok[loc] ? vm_data[loc] : 64'd0);
      end
      OP_DATA_ADD: begin
        if (vm_data_sz >= DATA_DEPTH) r.status = SC_CAPACITY;
        else begin
          vm_data[vm_data_sz] = (t.a == ALL_ONES) ? t.b : rd_reg(t.a);
          vm_data_ok[vm_data_sz] = 1;
          vm_data_sz++;
        end
      end
      OP_IPRINT: begin
        r.print_valid = 1;
        r.print_value = rd_reg(t.a);
      end
      OP_CALL:   r.status = enter_frame(t.a[31:0], t.pc, r.pc_value);
      OP_CALL_R: r.status = enter_frame(32'(rd_reg(t.a)), t.pc, r.pc_value);
      OP_RET:    r.status = unwind_frame(64'd0, r.pc_value);
      OP_RET_NM: r.status = unwind_frame(-t.a, r.pc_value);
      OP_RET_NP: r.status = unwind_frame(t.a, r.pc_value);
      OP_BEQ:    take = fl[0];
      OP_BGT:    take = fl[1];
      OP_BLT:    take = fl[2];
      OP_BLE:    take = fl[2] | fl[0];
      OP_BGE:    take = fl[1] | fl[0];
      OP_CMPI: begin
        d = rd_reg(t.a) - rd_reg(t.b);
        fl[2:0] = (d == 0) ? FLAG_Z : (d[63] ? FLAG_N : FLAG_C);
        wr_reg(64'(FLAG_INDEX), fl);
      end
      OP_SRESIZE, OP_DRESIZE: begin
        if (t.cmd == OP_SRESIZE) begin
          if (!size_after(64'(vm_stack_sz), t.a, STACK_DEPTH, nsz)) r.status = SC_CAPACITY;
          else begin
            for (int i = vm_stack_sz; i < nsz; i++) vm_stack_ok[i] = 0;
            vm_stack_sz = nsz;
          end
        end else begin
          if (!size_after(64'(vm_data_sz), t.a, DATA_DEPTH, nsz)) r.status = SC_CAPACITY;
          else begin
            for (int i = vm_data_sz; i < nsz; i++) vm_data_ok[i] = 0;
            vm_data_sz = nsz;
          end
        end
      end
      OP_DSIZE:  wr_reg(t.a, 64'(vm_data_sz));
      OP_SET_D_AV: begin
        if (vm_data_sz == 0) r.status = SC_DAT_EMPTY;
        else if (t.a >= vm_data_sz) r.status = SC_DAT_ADDR;
        else begin
          vm_data[t.a] = t.b;
          vm_data_ok[t.a] = 1;
        end
      end
      OP_EXIT:   r.pc_value = vm_exit_pc;
      default: ;
    endcase
    if (take) r.pc_value = t.a[31:0];
    r.pc_write = take || t.cmd == OP_EXIT ||
                 (t.cmd inside {OP_CALL, OP_CALL_R, OP_RET, OP_RET_NM, OP_RET_NP} &&
                  r.status == SC_OK);
    if (!r.pc_write) r.pc_value = '0;
    return r;
  endfunction

  // sender: holds a beat until it has been taken, otherwise offers the next one or idles
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && n_exec == acc_seen)) begin
      if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_instr = instr_q[0];
        in_tvalid = 1'b1;
        in_tuser  = cur_instr.cmd;
        in_tdata  = {cur_instr.pc, cur_instr.c, cur_instr.b, cur_instr.a};
        acc_seen  = n_exec;
      end else begin
        in_tvalid = 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n)
      out_tready = (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    if (hold_cycles != 0) hold_cycles = hold_cycles - 1;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      outcome_q.insert(outcome_q.size(), execute_instr(cur_instr));
      void'(instr_q.pop_front());
      n_exec++;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        want = outcome_q.pop_front();
        if (out_tuser[0] !== want.pc_write) begin
          $error("pc_write exp %0d got %0d", want.pc_write, out_tuser[0]);
          err_cnt++;
        end
        if (out_tdata[31:0] !== want.pc_value) begin
          $error("pc_value exp %h got %h", want.pc_value, out_tdata[31:0]);
          err_cnt++;
        end
        if (out_tuser[1] !== want.print_valid) begin
          $error("print_valid exp %0d got %0d", want.print_valid, out_tuser[1]);
          err_cnt++;
        end
        if (out_tdata[95:32] !== want.print_value) begin
          $error("print_value exp %h got %h", want.print_value, out_tdata[95:32]);
          err_cnt++;
        end
        if (out_tdata[99:96] !== want.status) begin
          $error("status exp %0d got %0d", want.status, out_tdata[99:96]);
          err_cnt++;
        end
        if (want.pc_write) n_redirect++;
        if (want.print_valid) n_print++;
        if (want.status != SC_OK) n_fault++;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // register index: mostly valid, sometimes absent or wild
  function automatic logic [63:0] rand_reg();
    case ($urandom_range(0, 19))
      0:       return ALL_ONES;
      1:       return rand64();
      2:       return 64'(NUM_REGS);
      default: return 64'($urandom_range(0, NUM_REGS - 1));
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return rand64();
      1:       return 64'h7fff_ffff_ffff_ffff;
      2:       return 64'h8000_0000_0000_0000;
      default: return 64'($signed($urandom_range(0, 40)) - 8);
    endcase
  endfunction

  function automatic logic [63:0] rand_delta();
    if ($urandom_range(0, 15) == 0) return rand_word();
    return 64'($signed($urandom_range(0, 24)) - 10);
  endfunction

  task automatic queue_instr(logic [4:0] cmd, logic [63:0] a, logic [63:0] b,
                             logic [63:0] c);
    instr_t t;
    t = '{cmd: cmd, a: a, b: b, c: c, pc: $urandom};
    instr_q.insert(instr_q.size(), t);
  endtask

  task automatic queue_random(int count);
    logic [4:0] cmd;
    int         w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 2) begin
        // deep call chain to reach the frame limit
        for (int k = 0; k < FRAME_DEPTH + 1; k++) queue_instr(OP_CALL, rand64(), 0, 0);
        i += FRAME_DEPTH;
        continue;
      end
      if (w < 12) cmd = OP_PUSH_C;
      else if (w < 18) cmd = OP_DATA_ADD;
      else cmd = 5'($urandom_range(0, 31));
      case (cmd)
        OP_PUSH_C, OP_MOV:          queue_instr(cmd, (cmd == OP_MOV) ? rand_reg() : rand_word(),
                                                rand_word(), rand64());
        OP_STORE_L, OP_LOAD_L,
        OP_STORE_G, OP_LOAD_G:      queue_instr(cmd, rand_reg(), rand_reg(),
                                                $urandom_range(0, 3) == 0 ? rand64()
                                                : 64'($urandom_range(0, 12)));
        OP_DATA_ADD:                queue_instr(cmd, $urandom_range(0, 1) ? ALL_ONES : rand_reg(),
                                                rand_word(), rand64());
        OP_SET_D_AV:                queue_instr(cmd, $urandom_range(0, 7) == 0 ? rand64()
                                                : 64'($urandom_range(0, 20)), rand_word(),
                                                rand64());
        OP_CALL, OP_BEQ, OP_BGT, OP_BLT, OP_BLE, OP_BGE:
                                    queue_instr(cmd, rand64(), rand64(), rand64());
        OP_RET_NM, OP_RET_NP, OP_SRESIZE, OP_DRESIZE:
                                    queue_instr(cmd, rand_delta(), rand64(), rand64());
        OP_IADD_C, OP_ISUB_C:       queue_instr(cmd, rand_reg(), rand_reg(), rand_word());
        default:                    queue_instr(cmd, rand_reg(), rand_reg(), rand_reg());
      endcase
    end
  endtask

  task automatic drain();
    while (instr_q.size() != 0 || in_tvalid || outcome_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_exit_pc(logic [31:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    vm_exit_pc = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int count, logic [31:0] xpc);
    write_exit_pc(xpc);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(count);
    drain();
  endtask

  initial begin
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    out_tready = 0; cfg_valid = 0; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0; acc_seen = 0;
    err_cnt = 0; n_exec = 0; n_redirect = 0; n_print = 0; n_fault = 0;
    foreach (vm_regs[i]) vm_regs[i] = '0;
    foreach (vm_stack_ok[i]) vm_stack_ok[i] = 0;
    foreach (vm_data_ok[i]) vm_data_ok[i] = 0;
    vm_stack_sz = 0; vm_data_sz = 0; vm_frm_cnt = 0; vm_exit_pc = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_exit_pc(32'h0000_0000);
    // directed: faults on empty stores, extremes, every branch kind, frames
    queue_instr(OP_INVALID, 0, 0, 0);
    queue_instr(OP_POP_R, 1, 0, 0);
    queue_instr(OP_LOAD_L, 1, ALL_ONES, 0);
    queue_instr(OP_STORE_G, 1, ALL_ONES, 0);
    queue_instr(OP_RET, 0, 0, 0);
    queue_instr(OP_MOV, 0, 64'h7fff_ffff_ffff_ffff, 0);
    queue_instr(OP_MOV, 1, 64'h8000_0000_0000_0000, 0);
    queue_instr(OP_IADD_C, 2, 0, 64'd1);
    queue_instr(OP_ISUB_R, 3, 1, 0);
    queue_instr(OP_IADD_R, 4, 0, 1);
    queue_instr(OP_IPRINT, 2, 0, 0);
    queue_instr(OP_CMPI, 0, 1, 0);
    queue_instr(OP_BGT, 64'hffff_ffff_ffff_ffff, 0, 0);
    queue_instr(OP_BLT, 64'h1234, 0, 0);
    queue_instr(OP_BEQ, 64'h1234, 0, 0);
    queue_instr(OP_BLE, 64'h55, 0, 0);
    queue_instr(OP_BGE, 64'h66, 0, 0);
    queue_instr(OP_DRESIZE, ALL_ONES, 0, 0);
    queue_instr(OP_SRESIZE, 64'd300, 0, 0);
    queue_instr(OP_DATA_ADD, ALL_ONES, 64'hdead_beef_cafe_f00d, 0);
    queue_instr(OP_DRESIZE, 64'd3, 0, 0);
    queue_instr(OP_LOAD_G, 5, ALL_ONES, 64'd2);
    queue_instr(OP_SET_D_AV, 64'd4, 64'd7, 0);
    queue_instr(OP_PUSH_R, 0, 0, 0);
    queue_instr(OP_CALL_R, 0, 0, 0);
    queue_instr(OP_RET_NM, 64'd5, 0, 0);
    queue_instr(OP_RET_NP, 64'd1, 0, 0);
    queue_instr(OP_DSIZE, 6, 0, 0);
    queue_instr(OP_EXIT, 0, 0, 0);
    queue_instr(OP_NOOP, rand64(), rand64(), rand64());
    drain();

    run_phase(0, 0, 200, 32'hffff_ffff);
    run_phase(74, 0, 200, $urandom);
    run_phase(0, 74, 200, 32'h0000_0001);
    run_phase(33, 33, 200, 32'h0000_0000);

    // receiver back-pressure while the sender keeps offering
    write_exit_pc($urandom);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 200;
    queue_random(50);
    drain();

    $display("executed %0d instructions: %0d pc redirects, %0d prints, %0d faulting",
             n_exec, n_redirect, n_print, n_fault);
    $display("covered five idle/stall settings and several exit_pc values");
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAIL");
    $finish;
  end

endmodule
